@@ src/vtea_pkg.sv @@
// Shared types, constants and helpers for the vertex transform / edge assembly block.
// No dependencies; every other file imports this package.
`default_nettype none

package vtea_pkg;

  // Matrix entries are fixed-width signed fixed point
  localparam int unsigned MAT_ENTRY_W = 16;
  localparam int unsigned MAT_ROW_W   = 4 * MAT_ENTRY_W;
  localparam int unsigned NUM_ROWS    = 3;

  // Default datapath format
  localparam int unsigned DEF_COORD_WIDTH = 16;
  localparam int unsigned DEF_FRAC_BITS   = 8;

  // Vertex queue between transform and assembly
  localparam int unsigned QUEUE_DEPTH = 4;

  // Polygon sizes, stored in the 3-bit vertex counter
  localparam logic [2:0] TRI_VERTS  = 3'd3;
  localparam logic [2:0] QUAD_VERTS = 3'd4;
  localparam logic [2:0] NO_VERTS   = 3'd0;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_QUAD = 2'd2
  } poly_mode_e;

  typedef enum logic [1:0] {
    CFG_POLY_MODE = 2'd0,
    CFG_ROW0      = 2'd1,
    CFG_ROW1      = 2'd2,
    CFG_ROW2      = 2'd3
  } cfg_index_e;

  // Configuration seen by the datapath
  typedef struct packed {
    poly_mode_e                            mode;
    logic [NUM_ROWS-1:0][MAT_ROW_W-1:0]   rows;
  } cfg_t;

  // Vertices per polygon for a mode; zero means no assembly
  function automatic logic [2:0] mode_limit(input poly_mode_e mode);
    logic [2:0] lim;
    unique case (mode)
      MODE_TRI:  lim = TRI_VERTS;
      MODE_QUAD: lim = QUAD_VERTS;
      default:   lim = NO_VERTS;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

@@ src/vtea_xform.sv @@
// Front end: accepts vertices and runs the three-row matrix transform in a
// three-stage pipeline (multiply, sum and round, shift and saturate). Uses vtea_pkg.
`default_nettype none

module vtea_xform #(
  parameter int unsigned COORD_WIDTH = vtea_pkg::DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = vtea_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vtea_pkg::cfg_t              cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0][COORD_WIDTH-1:0] in_vert_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0][COORD_WIDTH-1:0]      out_vert_o
);
  import vtea_pkg::*;

  localparam int unsigned PW = MAT_ENTRY_W + COORD_WIDTH;
  localparam int unsigned TW = MAT_ENTRY_W + FRAC_BITS;
  localparam int unsigned SW = ((PW > TW) ? PW : TW) + 3;

  localparam logic signed [SW-1:0] HALF   = (SW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SW-1:0] LIM_HI = {{(SW-COORD_WIDTH+1){1'b0}},
                                             {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] LIM_LO = ~LIM_HI;

  logic                          v1_q, v2_q, v3_q;
  logic                          adv;
  logic signed [PW-1:0]          prod_d [3][3];
  logic signed [PW-1:0]          prod_q [3][3];
  logic signed [SW-1:0]          trans_d [3];
  logic signed [SW-1:0]          trans_q [3];
  logic signed [SW-1:0]          sum_d [3];
  logic signed [SW-1:0]          sum_q [3];
  logic signed [SW-1:0]          shr [3];
  logic [2:0][COORD_WIDTH-1:0]   coord_d, coord_q;

  // Advance the whole pipe unless the last stage is blocked
  assign adv         = ~v3_q | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v3_q;
  assign out_vert_o  = coord_q;

  // Stage 1: one multiplier per matrix entry, translation scaled by one
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(cfg_i.rows[r][c*MAT_ENTRY_W +: MAT_ENTRY_W]) *
                       $signed(in_vert_i[c]);
      end
      trans_d[r] = SW'($signed(cfg_i.rows[r][3*MAT_ENTRY_W +: MAT_ENTRY_W])) <<< FRAC_BITS;
    end
  end

  // Stage 2: add the row terms and the rounding half
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]) +
                 trans_q[r] + HALF;
    end
  end

  // Stage 3: floor by the fraction and clamp to the coordinate range
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shr[r] = sum_q[r] >>> FRAC_BITS;
      if (shr[r] > LIM_HI) begin
        coord_d[r] = LIM_HI[COORD_WIDTH-1:0];
      end else if (shr[r] < LIM_LO) begin
        coord_d[r] = LIM_LO[COORD_WIDTH-1:0];
      end else begin
        coord_d[r] = shr[r][COORD_WIDTH-1:0];
      end
    end
  end

  // Track stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= prod_d;
      trans_q <= trans_d;
      sum_q   <= sum_d;
      coord_q <= coord_d;
    end
  end

endmodule

`default_nettype wire

@@ src/vtea_fifo.sv @@
// Short vertex queue that decouples the transform pipe from edge assembly.
// Flip-flop storage, depth from vtea_pkg::QUEUE_DEPTH (power of two).
`default_nettype none

module vtea_fifo #(
  parameter int unsigned COORD_WIDTH = vtea_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_valid_i,
  output logic                             push_ready_o,
  input  wire logic [2:0][COORD_WIDTH-1:0] push_data_i,
  output logic                             pop_valid_o,
  input  wire logic                        pop_ready_i,
  output logic [2:0][COORD_WIDTH-1:0]      pop_data_o
);
  import vtea_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [2:0][COORD_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("vertex queue occupancy out of range");
`endif

endmodule

`default_nettype wire

@@ src/vtea_asm.sv @@
// Back end: polygon edge assembly with an output register and a pending
// closing-edge flag. Keeps first/previous vertex and count. Uses vtea_pkg.
`default_nettype none

module vtea_asm #(
  parameter int unsigned COORD_WIDTH = vtea_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vtea_pkg::poly_mode_e        mode_i,
  input  wire logic                        vtx_valid_i,
  output logic                             vtx_ready_o,
  input  wire logic [2:0][COORD_WIDTH-1:0] vtx_i,
  output logic                             edge_valid_o,
  input  wire logic                        edge_ready_i,
  output logic [2:0][COORD_WIDTH-1:0]      edge_start_o,
  output logic [2:0][COORD_WIDTH-1:0]      edge_end_o,
  output logic                             edge_closing_o,
  output logic                             edge_last_o
);
  import vtea_pkg::*;

  logic [2:0]                  cnt_q, cnt_d, cnt_inc, limit;
  logic                        have_q, have_d;
  logic [2:0][COORD_WIDTH-1:0] first_q, first_d, prev_q, prev_d;
  logic                        pend_q, pend_d;
  logic                        ov_q, ov_d;
  logic [2:0][COORD_WIDTH-1:0] os_q, os_d, oe_q, oe_d;
  logic                        oc_q, oc_d, ol_q, ol_d;
  logic                        slot_free, pop, closing;

  assign limit     = mode_limit(mode_i);
  assign slot_free = ~ov_q | edge_ready_i;
  assign vtx_ready_o = ~pend_q & slot_free;
  assign pop       = vtx_valid_i & vtx_ready_o;
  assign cnt_inc   = cnt_q + 3'd1;
  assign closing   = (cnt_inc >= limit);

  assign edge_valid_o   = ov_q;
  assign edge_start_o   = os_q;
  assign edge_end_o     = oe_q;
  assign edge_closing_o = oc_q;
  assign edge_last_o    = ol_q;

  // Emit the pending closing edge first, else assemble the popped vertex
  always_comb begin
    cnt_d   = cnt_q;
    have_d  = have_q;
    first_d = first_q;
    prev_d  = prev_q;
    pend_d  = pend_q;
    ov_d    = ov_q & ~edge_ready_i;
    os_d    = os_q;
    oe_d    = oe_q;
    oc_d    = oc_q;
    ol_d    = ol_q;
    if (pend_q && slot_free) begin
      // closing edge: current vertex (now previous) back to the first
      os_d   = prev_q;
      oe_d   = first_q;
      oc_d   = 1'b1;
      ol_d   = 1'b1;
      ov_d   = 1'b1;
      pend_d = 1'b0;
    end else if (pop && (limit != NO_VERTS)) begin
      cnt_d  = closing ? 3'd0 : cnt_inc;
      have_d = ~closing;
      prev_d = vtx_i;
      if (!have_q) first_d = vtx_i;
      if (have_q) begin
        os_d   = prev_q;
        oe_d   = vtx_i;
        oc_d   = 1'b0;
        ol_d   = ~closing;
        ov_d   = 1'b1;
        pend_d = closing;
      end else if (closing) begin
        os_d = vtx_i;
        oe_d = vtx_i;
        oc_d = 1'b1;
        ol_d = 1'b1;
        ov_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      have_q <= 1'b0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      have_q <= have_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  // Vertex store and output payload
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    prev_q  <= prev_d;
    os_q    <= os_d;
    oe_q    <= oe_d;
    oc_q    <= oc_d;
    ol_q    <= ol_d;
  end

`ifndef SYNTHESIS
  a_pend_behind_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (ov_q && !ol_q))
    else $error("pending closing edge without an open edge in the output register");

  a_open_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ol_q) |-> pend_q)
    else $error("non-final edge shown with no closing edge queued");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> (cnt_q == 3'd0))
    else $error("vertex count nonzero with no polygon open");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("vertex count beyond largest open polygon");
`endif

endmodule

`default_nettype wire

@@ src/vertex_transform_edge_assembly_top.sv @@
// Top level: configuration registers, transform front end, vertex queue and
// edge assembly back end. Uses vtea_pkg, vtea_xform, vtea_fifo, vtea_asm.
//
// Usage:
//   s_axis carries one vertex per request: tdata = x, y, z from bit 0 up,
//   signed fixed point with FRAC_BITS fraction bits, COORD_WIDTH each.
//   m_axis carries one polygon edge per request: tdata = start x, y, z then
//   end x, y, z from bit 0 up; tuser = closing edge flag; tlast = last edge
//   caused by the vertex.
//   cfg writes poly_mode (index 0) and matrix rows 0..2 (indices 1..3);
//   write only while the block is idle. cfg_ready_o is always high.
// Path: an accepted vertex passes the three transform stages, the queue
//   storage and the assembly output register; its closing edge follows from
//   the pending flag once the output register is free again.
// Throughput: one vertex per cycle when it causes at most one edge and m_axis
//   does not stall; a closing vertex holds the single output register for its
//   own edge and then the closing edge. Reset clears mode, matrix, polygon
//   state and all queues. When m_axis stalls the queue fills and s_axis_tready_o drops.
`default_nettype none

module vertex_transform_edge_assembly_top #(
  parameter int unsigned COORD_WIDTH = vtea_pkg::DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = vtea_pkg::DEF_FRAC_BITS,
  parameter int unsigned IN_DW       = ((3 * COORD_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_DW      = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // vertex input
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [IN_DW-1:0]               s_axis_tdata_i,  // vert_x, vert_y, vert_z
  // edge output
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [OUT_DW-1:0]                   m_axis_tdata_o,  // start_x/y/z, end_x/y/z
  output logic                                m_axis_tuser_o,  // closing_edge
  output logic                                m_axis_tlast_o,  // last_of_run
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire vtea_pkg::cfg_index_e           cfg_index_i,
  input  wire logic [vtea_pkg::MAT_ROW_W-1:0] cfg_data_i
);
  import vtea_pkg::*;

  cfg_t                        cfg_q;
  logic [2:0][COORD_WIDTH-1:0] in_vert, xf_vert, q_vert, e_start, e_end;
  logic                        xf_valid, xf_ready, q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLY_MODE: cfg_q.mode    <= poly_mode_e'(cfg_data_i[1:0]);
        CFG_ROW0:      cfg_q.rows[0] <= cfg_data_i;
        CFG_ROW1:      cfg_q.rows[1] <= cfg_data_i;
        CFG_ROW2:      cfg_q.rows[2] <= cfg_data_i;
        default:       cfg_q         <= cfg_q;
      endcase
    end
  end

  // Unpack the vertex
  assign in_vert[0] = s_axis_tdata_i[0*COORD_WIDTH +: COORD_WIDTH];
  assign in_vert[1] = s_axis_tdata_i[1*COORD_WIDTH +: COORD_WIDTH];
  assign in_vert[2] = s_axis_tdata_i[2*COORD_WIDTH +: COORD_WIDTH];

  vtea_xform #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_vert_i   (in_vert),
    .out_valid_o (xf_valid),
    .out_ready_i (xf_ready),
    .out_vert_o  (xf_vert)
  );

  vtea_fifo #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (xf_valid),
    .push_ready_o (xf_ready),
    .push_data_i  (xf_vert),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_vert)
  );

  vtea_asm #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_asm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (cfg_q.mode),
    .vtx_valid_i    (q_valid),
    .vtx_ready_o    (q_ready),
    .vtx_i          (q_vert),
    .edge_valid_o   (m_axis_tvalid_o),
    .edge_ready_i   (m_axis_tready_i),
    .edge_start_o   (e_start),
    .edge_end_o     (e_end),
    .edge_closing_o (m_axis_tuser_o),
    .edge_last_o    (m_axis_tlast_o)
  );

  // Pack the edge, zero padding on top
  assign m_axis_tdata_o = OUT_DW'({e_end[2], e_end[1], e_end[0],
                                   e_start[2], e_start[1], e_start[0]});

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for vertex_transform_edge_assembly_top: random vertex and matrix stimulus
// against a self-contained edge predictor. Needs vtea_pkg and the block's RTL only.

module tb;
  import vtea_pkg::*;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned FRAC         = 8;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned SETTLE_WAIT  = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned REPORT_LIMIT = 60;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, sz;
    coord_t ex, ey, ez;
    logic   closing;
    logic   last;
  } edge_t;

  // Predicts transformed edges per vertex and matches them against the output stream
  class edge_scoreboard;
    logic [1:0]  mode;
    logic [63:0] rows [3];
    logic [2:0]  vert_count;
    bit          have_prev;
    coord_t      first_v [3];
    coord_t      prev_v [3];
    edge_t       pending_edges [$];
    int unsigned errors;

    function new();
      mode       = MODE_NONE;
      vert_count = '0;
      have_prev  = 1'b0;
      errors     = 0;
      for (int i = 0; i < 3; i++) begin
        rows[i]    = '0;
        first_v[i] = '0;
        prev_v[i]  = '0;
      end
    endfunction

    function void write_reg(cfg_index_e idx, logic [63:0] value);
      case (idx)
        CFG_POLY_MODE: mode = value[1:0];
        CFG_ROW0:      rows[0] = value;
        CFG_ROW1:      rows[1] = value;
        CFG_ROW2:      rows[2] = value;
        default:       ;
      endcase
    endfunction

    // One output coordinate: exact dot product, round half up, saturate
    function coord_t transform_row(int r, coord_t p [3]);
      longint acc;
      acc = 0;
      for (int c = 0; c < 3; c++)
        acc += longint'($signed(rows[r][16*c +: 16])) * longint'(p[c]);
      acc += longint'($signed(rows[r][63:48])) * (longint'(1) << FRAC);
      acc += longint'(1) << (FRAC - 1);
      acc = acc >>> FRAC;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return coord_t'(acc);
    endfunction

    function edge_t make_edge(coord_t a [3], coord_t b [3], logic closing, logic last);
      edge_t e;
      e.sx = a[0]; e.sy = a[1]; e.sz = a[2];
      e.ex = b[0]; e.ey = b[1]; e.ez = b[2];
      e.closing = closing;
      e.last    = last;
      return e;
    endfunction

    // Advance polygon state for an accepted vertex and queue the edges it causes
    function void note_vertex(coord_t x, coord_t y, coord_t z);
      coord_t     p [3];
      coord_t     v [3];
      logic [2:0] limit;
      bit         closing;
      case (mode)
        MODE_TRI:  limit = TRI_VERTS;
        MODE_QUAD: limit = QUAD_VERTS;
        default:   return;
      endcase
      p[0] = x; p[1] = y; p[2] = z;
      for (int i = 0; i < 3; i++) v[i] = transform_row(i, p);
      vert_count = vert_count + 3'd1;
      closing = (vert_count >= limit);
      if (!have_prev) begin
        first_v   = v;
        prev_v    = v;
        have_prev = 1'b1;
      end else begin
        pending_edges = {pending_edges, make_edge(prev_v, v, 1'b0, !closing)};
        prev_v = v;
      end
      if (closing) begin
        pending_edges = {pending_edges, make_edge(v, first_v, 1'b1, 1'b1)};
        have_prev  = 1'b0;
        vert_count = '0;
      end
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_edge(edge_t got);
      edge_t want;
      if (pending_edges.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected edge, expected none, actual (%0d %0d %0d)->(%0d %0d %0d) c%0d l%0d",
                   $time, got.sx, got.sy, got.sz, got.ex, got.ey, got.ez,
                   got.closing, got.last);
        return;
      end
      want = pending_edges.pop_front();
      compare_field("start_x", want.sx, got.sx);
      compare_field("start_y", want.sy, got.sy);
      compare_field("start_z", want.sz, got.sz);
      compare_field("end_x", want.ex, got.ex);
      compare_field("end_y", want.ey, got.ey);
      compare_field("end_z", want.ez, got.ez);
      compare_field("closing_edge", int'(want.closing), int'(got.closing));
      compare_field("last_of_run", int'(want.last), int'(got.last));
    endfunction

    function int unsigned outstanding();
      return pending_edges.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [47:0]   s_axis_tdata_i = '0;   // vert_x, vert_y, vert_z
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [95:0]   m_axis_tdata_o;        // start_x/y/z, end_x/y/z
  logic          m_axis_tuser_o;        // closing_edge
  logic          m_axis_tlast_o;        // last_of_run
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  cfg_index_e    cfg_index_i = CFG_POLY_MODE;
  logic [63:0]   cfg_data_i = '0;

  edge_scoreboard board;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left = 0;
  int unsigned    long_hold_cycles = 0;
  bit             src_steady = 1'b0;
  bit             sink_steady = 1'b0;
  edge_t          seen_edge;

  vertex_transform_edge_assembly_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL vertex_transform_edge_assembly_top");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic int unsigned source_gap();
    if (src_steady || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4, 5: return coord_t'($urandom_range(0, 2047) - 1024);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'h0100;
      4:       return 16'hFF00;
      5, 6, 7: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    if ($urandom_range(0, 5) == 0) return {$urandom, $urandom};
    return {rand_entry(), rand_entry(), rand_entry(), rand_entry()};
  endfunction

  // Check each accepted edge and pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_edge.sx      = m_axis_tdata_o[15:0];
      seen_edge.sy      = m_axis_tdata_o[31:16];
      seen_edge.sz      = m_axis_tdata_o[47:32];
      seen_edge.ex      = m_axis_tdata_o[63:48];
      seen_edge.ey      = m_axis_tdata_o[79:64];
      seen_edge.ez      = m_axis_tdata_o[95:80];
      seen_edge.closing = m_axis_tuser_o;
      seen_edge.last    = m_axis_tlast_o;
      board.check_edge(seen_edge);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (long_hold_cycles > 0) begin
      stall_left = long_hold_cycles - 1;
      long_hold_cycles = 0;
      m_axis_tready_i <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Offer one vertex after a random gap and hold it until the request is taken
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    int unsigned gap;
    gap = source_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_vertex(x, y, z);
  endtask

  task automatic set_reg(input cfg_index_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_matrix(input logic [63:0] r0, input logic [63:0] r1,
                             input logic [63:0] r2);
    set_reg(CFG_ROW0, r0);
    set_reg(CFG_ROW1, r1);
    set_reg(CFG_ROW2, r2);
  endtask

  // Drain all expected edges, then let vertices that cause none flush through
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    set_reg(CFG_POLY_MODE, {62'd0, mode});
  endtask

  initial begin
    int unsigned counted;
    int unsigned phase;
    int unsigned len;
    logic [1:0]  mode;

    board = new();
    counted = 0;
    phase = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Mode none out of reset: vertex is dropped
    send_vertex(16'h1234, 16'hFFFF, 16'h7FFF);
    settle();

    // Identity transform, one triangle over the coordinate extremes
    load_matrix(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                64'h0000_0100_0000_0000);
    set_mode(MODE_TRI);
    send_vertex(16'h7FFF, 16'h8000, 16'h0000);
    send_vertex(16'h8000, 16'h7FFF, 16'hFFFF);
    send_vertex(16'h0001, 16'hFFFF, 16'h0080);
    settle();

    // Saturating rows and half-LSB rounding, one quad
    load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                64'h0080_FF80_0080_0080);
    set_mode(MODE_QUAD);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h0001, 16'h0000, 16'h0000);
    send_vertex(16'hFFFF, 16'h0001, 16'h0003);
    settle();

    // Switch quad to triangles after three vertices: closes at once
    load_matrix(rand_row(), rand_row(), rand_row());
    for (int i = 0; i < 3; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
    settle();
    set_mode(MODE_TRI);
    send_vertex(rand_coord(), rand_coord(), rand_coord());

    // Switch triangles to quad after two vertices: count carries over
    for (int i = 0; i < 2; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
    settle();
    set_mode(MODE_QUAD);
    for (int i = 0; i < 2; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());

    // Mode none and the unused code mid-polygon leave the state alone
    send_vertex(rand_coord(), rand_coord(), rand_coord());
    settle();
    set_mode(MODE_NONE);
    send_vertex(rand_coord(), rand_coord(), rand_coord());
    settle();
    set_mode(MODE_UNUSED);
    send_vertex(rand_coord(), rand_coord(), rand_coord());
    settle();
    set_mode(MODE_QUAD);
    for (int i = 0; i < 3; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());

    // Random phases; polygons are left open across mode changes on purpose
    while (counted < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = MODE_TRI;
        4, 5, 6, 7: mode = MODE_QUAD;
        8:          mode = MODE_NONE;
        default:    mode = MODE_UNUSED;
      endcase
      len = (mode == MODE_NONE || mode == MODE_UNUSED) ?
            $urandom_range(2, 8) : $urandom_range(8, 60);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      // Hold the receiver off while vertices keep coming so the queue backs up
      if (phase == 3 || phase == 17) begin
        mode = MODE_TRI;
        len = 60;
        src_steady = 1'b1;
        long_hold_cycles = HOLD_CYCLES;
      end
      set_mode(mode);
      if ($urandom_range(0, 2) != 0) load_matrix(rand_row(), rand_row(), rand_row());
      for (int i = 0; i < len; i++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord());
        if (mode == MODE_TRI || mode == MODE_QUAD) counted++;
      end
      phase++;
    end

    settle();
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASS vertex_transform_edge_assembly_top");
    end else begin
      $display("FAIL vertex_transform_edge_assembly_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/vtea_pkg.sv
src/vtea_xform.sv
src/vtea_fifo.sv
src/vtea_asm.sv
src/vertex_transform_edge_assembly_top.sv
verif/tb.sv
